>>> rtl/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants of the positional list engine: opcodes, status
// codes, request and result structs, sequencer states.
// ----------------------------------------------------------------------------
package plist_pkg;

    localparam int PLIST_CAPACITY = 64;
    localparam int PLIST_POS_W    = 7;
    localparam int PLIST_VAL_W    = 32;

    typedef enum logic [2:0] {
        OP_INS_LAST  = 3'd0,
        OP_INS_FIRST = 3'd1,
        OP_INS_AT    = 3'd2,
        OP_DUMP      = 3'd3,
        OP_UPDATE_AT = 3'd4,
        OP_DEL_FIRST = 3'd5,
        OP_DEL_LAST  = 3'd6,
        OP_DEL_AT    = 3'd7
    } plist_op_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_EMPTY  = 2'd1,
        STAT_BADPOS = 2'd2,
        STAT_FULL   = 2'd3
    } plist_status_t;

    typedef struct packed {
        plist_op_t                opcode;
        logic [PLIST_POS_W-1:0]   position;
        logic signed [PLIST_VAL_W-1:0] item_value;
    } plist_in_t;

    typedef struct packed {
        logic signed [PLIST_VAL_W-1:0] element_value;
        plist_status_t            status;
        logic                     last_of_run;
    } plist_out_t;

    typedef struct packed {
        logic       valid;
        plist_out_t data;
    } plist_push_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INS_WR,
        S_DEL,
        S_DEL_WR,
        S_DUMP_RD,
        S_DUMP_PUSH,
        S_RESP
    } plist_state_t;

endpackage

>>> rtl/plist_store.sv
// ----------------------------------------------------------------------------
// plist_store
// List storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module plist_store #(
    parameter int DEPTH = plist_pkg::PLIST_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [AW-1:0]                        wr_addr,
    input  logic signed [plist_pkg::PLIST_VAL_W-1:0] wr_data,
    input  logic                                 rd_en,
    input  logic [AW-1:0]                        rd_addr,
    output logic signed [plist_pkg::PLIST_VAL_W-1:0] rd_data
);
    import plist_pkg::*;

    logic signed [PLIST_VAL_W-1:0] mem [DEPTH];
    logic signed [PLIST_VAL_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/plist_seq.sv
// ----------------------------------------------------------------------------
// plist_seq
// Sequencer: checks each request against the element count, then moves
// entries one at a time through the store to open or close a gap, writes an
// update in place, or walks the store for a dump.
// ----------------------------------------------------------------------------
module plist_seq #(
    parameter int CAPACITY = plist_pkg::PLIST_CAPACITY,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  plist_pkg::plist_in_t                 req,
    input  logic                                 out_free,
    output plist_pkg::plist_push_t               push,
    output logic                                 mem_we,
    output logic [AW-1:0]                        mem_waddr,
    output logic signed [plist_pkg::PLIST_VAL_W-1:0] mem_wdata,
    output logic                                 mem_re,
    output logic [AW-1:0]                        mem_raddr,
    input  logic signed [plist_pkg::PLIST_VAL_W-1:0] mem_rdata
);
    import plist_pkg::*;

    // compare width covers both the count and the position field
    localparam int KW = ((CW > PLIST_POS_W) ? CW : PLIST_POS_W) + 1;

    plist_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] tgt_reg, tgt_next;
    logic signed [PLIST_VAL_W-1:0] val_reg, val_next;
    plist_status_t status_reg, status_next;

    logic          accept;
    logic [KW-1:0] pos_k, cnt_k, cur1_k;
    logic          is_empty, is_full, pos_zero, pos_over, pos_past_end;
    logic          at_target, del_done, dump_last;

    // decoded request
    plist_state_t  dec_state;
    plist_status_t dec_status;
    logic [CW-1:0] dec_cur, dec_tgt;
    logic          dec_update;

    assign accept       = req_valid && (state_reg == S_IDLE);
    assign req_ready    = (state_reg == S_IDLE);
    assign pos_k        = KW'(req.position);
    assign cnt_k        = KW'(count_reg);
    assign cur1_k       = KW'(cur_reg) + KW'(1);
    assign is_empty     = (count_reg == '0);
    assign is_full      = (cnt_k >= KW'(CAPACITY));
    assign pos_zero     = (req.position == '0);
    assign pos_over     = (pos_k > cnt_k);
    assign pos_past_end = (pos_k > cnt_k + KW'(1));
    assign at_target    = (cur_reg == tgt_reg);
    assign del_done     = (cur1_k == cnt_k);
    assign dump_last    = (cur1_k == cnt_k);

    always_comb begin
        dec_state  = S_RESP;
        dec_status = STAT_OK;
        dec_cur    = count_reg;
        dec_tgt    = count_reg;
        dec_update = 1'b0;
        case (req.opcode)
            OP_INS_LAST: begin
                if (is_full) begin
                    dec_status = STAT_FULL;
                end else begin
                    dec_state = S_INS;
                end
            end
            OP_INS_FIRST: begin
                if (is_full) begin
                    dec_status = STAT_FULL;
                end else begin
                    dec_state = S_INS;
                    dec_tgt   = '0;
                end
            end
            OP_INS_AT: begin
                if (pos_zero) begin
                    dec_status = STAT_BADPOS;
                end else if ((pos_k >= KW'(2)) && is_empty) begin
                    dec_status = STAT_EMPTY;
                end else if (pos_past_end) begin
                    dec_status = STAT_BADPOS;
                end else if (is_full) begin
                    dec_status = STAT_FULL;
                end else begin
                    dec_state = S_INS;
                    dec_tgt   = CW'(pos_k - KW'(1));
                end
            end
            OP_DUMP: begin
                if (is_empty) begin
                    dec_status = STAT_EMPTY;
                end else begin
                    dec_state = S_DUMP_RD;
                    dec_cur   = '0;
                end
            end
            OP_UPDATE_AT: begin
                if (is_empty) begin
                    dec_status = STAT_EMPTY;
                end else if (pos_zero || pos_over) begin
                    dec_status = STAT_BADPOS;
                end else begin
                    dec_update = 1'b1;
                end
            end
            OP_DEL_FIRST: begin
                if (is_empty) begin
                    dec_status = STAT_EMPTY;
                end else begin
                    dec_state = S_DEL;
                    dec_cur   = '0;
                end
            end
            OP_DEL_LAST: begin
                if (is_empty) begin
                    dec_status = STAT_EMPTY;
                end else begin
                    dec_state = S_DEL;
                    dec_cur   = count_reg - CW'(1);
                end
            end
            default: begin
                if (is_empty) begin
                    dec_status = STAT_EMPTY;
                end else if (pos_zero || pos_over) begin
                    dec_status = STAT_BADPOS;
                end else begin
                    dec_state = S_DEL;
                    dec_cur   = CW'(pos_k - KW'(1));
                end
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = dec_state;
                end
            end
            S_INS: begin
                state_next = at_target ? S_RESP : S_INS_WR;
            end
            S_INS_WR: begin
                state_next = S_INS;
            end
            S_DEL: begin
                state_next = del_done ? S_RESP : S_DEL_WR;
            end
            S_DEL_WR: begin
                state_next = S_DEL;
            end
            S_DUMP_RD: begin
                state_next = S_DUMP_PUSH;
            end
            S_DUMP_PUSH: begin
                if (out_free) begin
                    state_next = dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath registers
    always_comb begin
        count_next  = count_reg;
        cur_next    = cur_reg;
        tgt_next    = tgt_reg;
        val_next    = val_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    cur_next    = dec_cur;
                    tgt_next    = dec_tgt;
                    val_next    = req.item_value;
                    status_next = dec_status;
                end
            end
            S_INS: begin
                if (at_target) begin
                    count_next = count_reg + CW'(1);
                end
            end
            S_INS_WR: begin
                cur_next = cur_reg - CW'(1);
            end
            S_DEL: begin
                if (del_done) begin
                    count_next = count_reg - CW'(1);
                end
            end
            S_DEL_WR: begin
                cur_next = cur_reg + CW'(1);
            end
            S_DUMP_PUSH: begin
                if (out_free) begin
                    cur_next = cur_reg + CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // store control and result push
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_reg[AW-1:0];
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = cur_reg[AW-1:0];
        push      = '0;
        case (state_reg)
            S_IDLE: begin
                if (accept && dec_update) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(pos_k - KW'(1));
                    mem_wdata = req.item_value;
                end
            end
            S_INS: begin
                if (at_target) begin
                    mem_we    = 1'b1;
                    mem_waddr = tgt_reg[AW-1:0];
                    mem_wdata = val_reg;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(cur_reg - CW'(1));
                end
            end
            S_INS_WR: begin
                mem_we = 1'b1;
            end
            S_DEL: begin
                if (!del_done) begin
                    mem_re    = 1'b1;
                    mem_raddr = AW'(cur1_k);
                end
            end
            S_DEL_WR: begin
                mem_we = 1'b1;
            end
            S_DUMP_RD: begin
                mem_re = 1'b1;
            end
            S_DUMP_PUSH: begin
                push.valid              = 1'b1;
                push.data.element_value = mem_rdata;
                push.data.status        = STAT_OK;
                push.data.last_of_run   = dump_last;
            end
            S_RESP: begin
                push.valid              = 1'b1;
                push.data.element_value = '0;
                push.data.status        = status_reg;
                push.data.last_of_run   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        tgt_reg    <= tgt_next;
        val_reg    <= val_next;
        status_reg <= status_next;
    end

endmodule

>>> rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to CAPACITY signed 32-bit values with positional insert,
// update, delete and dump, built around one store and a small sequencer.
//
//   channel   ports                      payload
//   request   s_valid s_ready s_data     plist_in_t  (opcode, position, value)
//   result    m_valid m_ready m_data     plist_out_t (element, status, last)
//
// An insert at list position p shifts the elements from p on up one place, a
// delete at p shifts those behind p down one place; each moved element costs a
// read and a write through the single store port pair. An update writes in
// place, errors only return a status and a dump pushes each element in turn.
// The request side is ready only while the sequencer is idle; results sit in
// an output register, so a stalled result blocks the sequencer only when the
// next one is due. Reset clears the element count; the store is not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine #(
    parameter int CAPACITY = plist_pkg::PLIST_CAPACITY
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  plist_pkg::plist_in_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output plist_pkg::plist_out_t  m_data
);
    import plist_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    plist_push_t push;
    logic        out_free;
    logic        mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic signed [PLIST_VAL_W-1:0] mem_wdata, mem_rdata;

    logic       m_valid_reg;
    plist_out_t m_data_reg;

    assign out_free = !m_valid_reg || m_ready;

    plist_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (s_data),
        .out_free  (out_free),
        .push      (push),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    plist_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // output register parts the sequencer from the result side
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (push.valid && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid && out_free) begin
            m_data_reg <= push.data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> bench/positional_list_engine_test.sv
// ----------------------------------------------------------------------------
// positional_list_engine_test
// Self-checking bench for the positional list engine. Requests go in over the
// valid/ready input channel and every result is checked against a list model
// kept alongside: empty-list and bad-position errors, edits at both ends and
// in the middle, a full list, then random mixes that grow and shrink the list,
// with random idling on both channels.
// ----------------------------------------------------------------------------
module positional_list_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import plist_pkg::*;

    localparam int CAP          = PLIST_CAPACITY;
    localparam int MAX_GAP      = 17;
    localparam int DRAIN_CYCLES = 400;
    localparam int WAIT_LIMIT   = 200000;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    plist_in_t  s_data  = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    plist_out_t m_data;

    // list model
    logic signed [PLIST_VAL_W-1:0] model_store [0:CAP-1];
    int                            model_count = 0;

    plist_out_t  pending_results [$];
    int          failures        = 0;
    int          results_checked = 0;
    int unsigned op_seen [8]     = '{default: 0};
    bit          no_idle         = 1'b0;

    positional_list_engine #(
        .CAPACITY(CAP)
    ) uut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #10 aclk = ~aclk;

    function automatic plist_out_t status_result(input plist_status_t st);
        plist_out_t res;
        res.element_value = '0;
        res.status        = st;
        res.last_of_run   = 1'b1;
        return res;
    endfunction

    task automatic insert_entry(input int idx, input logic signed [PLIST_VAL_W-1:0] val);
        for (int i = model_count; i > idx; i--)
            model_store[i] = model_store[i-1];
        model_store[idx] = val;
        model_count++;
    endtask

    task automatic remove_entry(input int idx);
        for (int i = idx; i < model_count - 1; i++)
            model_store[i] = model_store[i+1];
        model_count--;
    endtask

    // apply one accepted request to the model and queue what it should produce
    task automatic predict_list_op(input plist_in_t req);
        int            pos;
        plist_status_t st;
        plist_out_t    res;
        bit            dumped;
        pos    = req.position;
        st     = STAT_OK;
        dumped = 1'b0;
        op_seen[int'(req.opcode)]++;
        case (req.opcode)
            OP_INS_LAST: begin
                if (model_count >= CAP) st = STAT_FULL;
                else insert_entry(model_count, req.item_value);
            end
            OP_INS_FIRST: begin
                if (model_count >= CAP) st = STAT_FULL;
                else insert_entry(0, req.item_value);
            end
            OP_INS_AT: begin
                if (pos == 0) st = STAT_BADPOS;
                else if (pos >= 2 && model_count == 0) st = STAT_EMPTY;
                else if (pos > model_count + 1) st = STAT_BADPOS;
                else if (model_count >= CAP) st = STAT_FULL;
                else insert_entry(pos - 1, req.item_value);
            end
            OP_DUMP: begin
                if (model_count == 0) begin
                    st = STAT_EMPTY;
                end else begin
                    for (int i = 0; i < model_count; i++) begin
                        res.element_value = model_store[i];
                        res.status        = STAT_OK;
                        res.last_of_run   = (i == model_count - 1);
                        pending_results.push_back(res);
                    end
                    dumped = 1'b1;
                end
            end
            OP_UPDATE_AT: begin
                if (model_count == 0) st = STAT_EMPTY;
                else if (pos == 0 || pos > model_count) st = STAT_BADPOS;
                else model_store[pos-1] = req.item_value;
            end
            OP_DEL_FIRST: begin
                if (model_count == 0) st = STAT_EMPTY;
                else remove_entry(0);
            end
            OP_DEL_LAST: begin
                if (model_count == 0) st = STAT_EMPTY;
                else remove_entry(model_count - 1);
            end
            default: begin
                if (model_count == 0) st = STAT_EMPTY;
                else if (pos == 0 || pos > model_count) st = STAT_BADPOS;
                else remove_entry(pos - 1);
            end
        endcase
        if (!dumped)
            pending_results.push_back(status_result(st));
    endtask

    // called at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input plist_op_t op, input int pos,
                                input logic signed [PLIST_VAL_W-1:0] val);
        plist_in_t req;
        int        gap;
        req.opcode     = op;
        req.position   = 7'(pos);
        req.item_value = val;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_list_op(req);
    endtask

    function automatic logic signed [PLIST_VAL_W-1:0] random_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return '0;
            3:       return -1;
            default: return $urandom;
        endcase
    endfunction

    // mostly within the list, now and then anywhere in the field
    function automatic int random_position();
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, 127);
        return $urandom_range(0, model_count + 1);
    endfunction

    function automatic plist_op_t random_operation(input int ins_weight);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6) return OP_DUMP;
        if (r < 6 + ins_weight) begin
            case ($urandom_range(0, 2))
                0:       return OP_INS_LAST;
                1:       return OP_INS_FIRST;
                default: return OP_INS_AT;
            endcase
        end
        if (r < 18 + ins_weight) return OP_UPDATE_AT;
        case ($urandom_range(0, 2))
            0:       return OP_DEL_FIRST;
            1:       return OP_DEL_LAST;
            default: return OP_DEL_AT;
        endcase
    endfunction

    task automatic test_empty_list();
        send_request(OP_DUMP, 0, '0);
        send_request(OP_DEL_FIRST, 1, '0);
        send_request(OP_DEL_LAST, 1, '0);
        send_request(OP_DEL_AT, 1, '0);
        send_request(OP_UPDATE_AT, 1, 32'sh1234_5678);
        send_request(OP_INS_AT, 0, 32'sh1111_1111);
        send_request(OP_INS_AT, 2, 32'sh2222_2222);
        send_request(OP_INS_AT, 127, 32'sh3333_3333);
    endtask

    task automatic test_edits();
        send_request(OP_INS_AT, 1, 32'sh7fff_ffff);
        send_request(OP_INS_LAST, 0, 32'sh8000_0000);
        send_request(OP_INS_FIRST, 127, '0);
        // position one past the end appends
        send_request(OP_INS_AT, 4, -1);
        send_request(OP_INS_AT, 6, 32'sh0bad_0bad);
        send_request(OP_INS_AT, 2, 32'sh5555_aaaa);
        send_request(OP_UPDATE_AT, 0, 32'sh0000_0001);
        send_request(OP_UPDATE_AT, 6, 32'sh0000_0002);
        send_request(OP_UPDATE_AT, 3, 32'shaaaa_5555);
        send_request(OP_DEL_AT, 0, '0);
        send_request(OP_DEL_AT, 6, '0);
        send_request(OP_DEL_AT, 2, '0);
        send_request(OP_DUMP, 0, '0);
        send_request(OP_DEL_FIRST, 0, '0);
        send_request(OP_DEL_LAST, 0, '0);
        send_request(OP_DUMP, 0, '0);
    endtask

    task automatic test_capacity();
        no_idle = 1'b1;
        while (model_count < CAP) begin
            case ($urandom_range(0, 2))
                0:       send_request(OP_INS_LAST, $urandom_range(0, 127), random_value());
                1:       send_request(OP_INS_FIRST, $urandom_range(0, 127), random_value());
                default: send_request(OP_INS_AT, $urandom_range(1, model_count + 1),
                                      random_value());
            endcase
        end
        no_idle = 1'b0;
        send_request(OP_INS_LAST, 0, random_value());
        send_request(OP_INS_FIRST, 0, random_value());
        send_request(OP_INS_AT, 1, random_value());
        send_request(OP_INS_AT, CAP + 1, random_value());
        send_request(OP_INS_AT, CAP + 2, random_value());
        send_request(OP_INS_AT, 127, random_value());
        send_request(OP_INS_AT, 0, random_value());
        send_request(OP_UPDATE_AT, CAP, random_value());
        send_request(OP_UPDATE_AT, CAP + 1, random_value());
        send_request(OP_DUMP, 0, '0);
        while (model_count > 0) begin
            case ($urandom_range(0, 2))
                0:       send_request(OP_DEL_FIRST, $urandom_range(0, 127), random_value());
                1:       send_request(OP_DEL_LAST, $urandom_range(0, 127), random_value());
                default: send_request(OP_DEL_AT, $urandom_range(1, model_count),
                                      random_value());
            endcase
            if (model_count == CAP / 2)
                send_request(OP_DUMP, 0, '0);
        end
        send_request(OP_DUMP, 0, '0);
    endtask

    task automatic test_random_mix();
        int growth [9] = '{70, 70, 70, 45, 20, 20, 70, 45, 20};
        for (int b = 0; b < 9; b++) begin
            no_idle = (b % 3 == 2);
            for (int i = 0; i < 40; i++)
                send_request(random_operation(growth[b]), random_position(), random_value());
        end
        no_idle = 1'b0;
    endtask

    // result side: random back-pressure and the check of every result
    initial begin
        int         stall;
        plist_out_t got;
        plist_out_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            got = m_data;
            if (pending_results.size() == 0) begin
                failures++;
                $display("%0t: unexpected result: expected none, actual element %0d status %0d last %0b",
                         $time, got.element_value, got.status, got.last_of_run);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.element_value !== want.element_value) begin
                    failures++;
                    $display("%0t: element_value mismatch: expected %0d, actual %0d",
                             $time, want.element_value, got.element_value);
                end
                if (got.status !== want.status) begin
                    failures++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, got.status);
                end
                if (got.last_of_run !== want.last_of_run) begin
                    failures++;
                    $display("%0t: last_of_run mismatch: expected %0b, actual %0b",
                             $time, want.last_of_run, got.last_of_run);
                end
            end
        end
    end

    initial begin
        int waited;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_empty_list();
        test_edits();
        test_capacity();
        test_random_mix();
        s_valid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < WAIT_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            failures++;
            $display("%0t: missing results: expected %0d more, actual 0",
                     $time, pending_results.size());
        end
        $display("covered %0d inserts, %0d updates, %0d deletes and %0d dumps",
                 op_seen[int'(OP_INS_LAST)] + op_seen[int'(OP_INS_FIRST)]
                 + op_seen[int'(OP_INS_AT)], op_seen[int'(OP_UPDATE_AT)],
                 op_seen[int'(OP_DEL_FIRST)] + op_seen[int'(OP_DEL_LAST)]
                 + op_seen[int'(OP_DEL_AT)], op_seen[int'(OP_DUMP)]);
        $display("%0d results compared with the list model, %0d failures",
                 results_checked, failures);
        if (failures == 0) begin
            $display("[positional_list_engine] OK");
        end else begin
            $display("[positional_list_engine] ERROR");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("[positional_list_engine] ERROR");
        $finish;
    end

endmodule

>>> positional_list_engine.f
rtl/plist_pkg.sv
rtl/plist_store.sv
rtl/plist_seq.sv
rtl/positional_list_engine.sv
bench/positional_list_engine_test.sv
